// File: rtl/core/hack_assembly_line_encoder_assert.svh
`ifndef HACK_ASSEMBLY_LINE_ENCODER_ASSERT_SVH
`define HACK_ASSEMBLY_LINE_ENCODER_ASSERT_SVH
// check that a condition implies a consequence on the same edge
`define HALE_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);
// check that a condition implies a consequence on the next edge
`define HALE_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);
`endif

// File: rtl/core/hale_pkg.sv
package hale_pkg;
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_ADDRESS = 3'd1;
    localparam logic [2:0] ERR_FORMAT  = 3'd2;
    localparam logic [2:0] ERR_COMP    = 3'd3;
    localparam logic [2:0] ERR_DEST    = 3'd4;
    localparam logic [2:0] ERR_JUMP    = 3'd5;

    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_A     = 8'h41;

    typedef struct packed {
        logic [15:0] instruction;
        logic [2:0]  error_code;
        logic [15:0] line_number;
    } t_result;

    typedef struct packed {
        logic        ok;
        logic [15:0] line_number;
        logic [15:0] addr;
        logic        is_address;
        logic        addr_bad;
        logic        format_bad;
        logic        semicolon_first;
        logic        seen_semicolon;
        logic [31:0] comp;
        logic [3:0]  comp_len;
        logic [31:0] dest;
        logic [3:0]  dest_len;
        logic [31:0] jump;
        logic [3:0]  jump_len;
    } t_line;
endpackage

// File: rtl/core/hale_stream_if.sv
interface hale_stream_if #(parameter int WIDTH = 8);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/hale_front.sv
module hale_front #(
    parameter int TOKEN_CHARS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_ch,
    input  logic               i_end_of_text,
    output logic               o_ready,
    output logic               o_line_valid,
    output hale_pkg::t_line    o_line,
    input  logic               i_line_ready,
    input  logic               i_halted
);
    import hale_pkg::*;

    localparam int LW = $clog2(TOKEN_CHARS + 2);
    localparam logic [LW-1:0] CAP = LW'(TOKEN_CHARS);

    logic [15:0] r_line_count;
    logic r_in_comment, r_slash, r_started, r_is_addr, r_addr_bad, r_digit;
    logic [15:0] r_addr;
    logic r_eq, r_semi, r_semi_first;
    logic [7:0] r_part [3][TOKEN_CHARS];
    logic [LW-1:0] r_len [3];

    logic [7:0] n_part [3][TOKEN_CHARS];
    logic [LW-1:0] n_len [3];
    logic n_in_comment, n_slash, n_started, n_is_addr, n_addr_bad, n_digit;
    logic [15:0] n_addr, n_line_count;
    logic n_eq, n_semi, n_semi_first;
    logic fire, finish, clear;
    logic [15:0] line_next;
    t_line line;

    function automatic logic [31:0] pack_part(input logic [7:0] p [TOKEN_CHARS]);
        logic [31:0] v;
        v = '0;
        for (int i = 0; i < 4; i++) begin
            if (i < TOKEN_CHARS) v[i*8 +: 8] = p[i];
        end
        return v;
    endfunction

    function automatic logic [3:0] clip_len(input logic [LW-1:0] l);
        return (l > CAP || l > LW'(4)) ? 4'd15 : 4'(l);
    endfunction

    assign o_ready = i_halted ? 1'b1 : (!finish || i_line_ready);
    assign fire = i_valid && o_ready && !i_halted;

    always_comb begin
        logic       kc;
        logic [7:0] c;
        logic [1:0] slot;
        n_part = r_part; n_len = r_len;
        n_in_comment = r_in_comment; n_slash = r_slash; n_started = r_started;
        n_is_addr = r_is_addr; n_addr_bad = r_addr_bad; n_digit = r_digit;
        n_addr = r_addr; n_eq = r_eq; n_semi = r_semi; n_semi_first = r_semi_first;
        finish = 1'b0;
        kc = 1'b0;
        c = CH_SLASH;
        slot = 2'd0;
        for (int k = 0; k < 2; k++) begin
            kc = 1'b0;
            c = CH_SLASH;
            slot = 2'd0;
            if (k == 0) begin
                if (i_end_of_text) begin
                    finish = r_started;
                    kc = r_started && r_slash;
                end else if (i_ch == CH_NL) begin
                    finish = 1'b1;
                    kc = r_slash;
                end else if (!r_in_comment && r_slash) begin
                    kc = (i_ch != CH_SLASH);
                end
                if (kc) n_slash = 1'b0;
            end else begin
                c = i_ch;
                kc = !i_end_of_text && i_ch != CH_NL && !r_in_comment
                     && !(r_slash) && i_ch != CH_SLASH && i_ch != CH_SPACE
                     && i_ch != CH_TAB && i_ch != CH_CR;
                if (!i_end_of_text && i_ch != CH_NL && !r_in_comment && r_slash
                    && i_ch != CH_SLASH && i_ch != CH_SPACE && i_ch != CH_TAB
                    && i_ch != CH_CR) kc = 1'b1;
            end
            if (kc) begin
                if (!n_is_addr && !n_eq && !n_semi && n_len[0] == '0 && c == CH_AT) begin
                    n_is_addr = 1'b1;
                end else if (n_is_addr) begin
                    if (c >= CH_0 && c <= CH_9) begin
                        n_addr = 16'(({n_addr, 3'b0}) + ({n_addr, 1'b0}) + 19'(c - CH_0));
                        n_digit = 1'b1;
                    end else n_addr_bad = 1'b1;
                end else if (c == CH_EQ && !n_eq && !n_semi) begin
                    n_eq = 1'b1;
                end else if (c == CH_SEMI && !n_semi) begin
                    n_semi = 1'b1;
                    if (!n_eq) n_semi_first = 1'b1;
                end else begin
                    if (!n_eq && !n_semi) slot = 2'd0;
                    else if (n_semi && !n_semi_first) slot = 2'd2;
                    else slot = 2'd1;
                    for (int j = 0; j < TOKEN_CHARS; j++) begin
                        if (n_len[slot] == LW'(j)) n_part[slot][j] = c;
                    end
                    if (n_len[slot] <= CAP) n_len[slot] = n_len[slot] + 1'b1;
                end
            end
        end
        if (!i_end_of_text && i_ch != CH_NL) begin
            n_started = 1'b1;
            if (!r_in_comment) begin
                if (r_slash && i_ch == CH_SLASH) begin
                    n_in_comment = 1'b1; n_slash = 1'b0;
                end else if (i_ch == CH_SLASH) n_slash = 1'b1;
            end
        end
    end

    assign clear = finish;
    assign line_next = (r_line_count == 16'hFFFF) ? r_line_count : r_line_count + 16'd1;
    assign n_line_count = finish ? line_next : r_line_count;

    always_comb begin
        line.ok = n_is_addr || n_eq || n_semi || n_len[0] != '0;
        line.line_number = line_next;
        line.addr = n_addr;
        line.is_address = n_is_addr;
        line.addr_bad = n_addr_bad || !n_digit;
        line.format_bad = !n_eq && !n_semi;
        line.semicolon_first = n_semi_first;
        line.seen_semicolon = n_semi;
        line.comp = n_semi_first ? pack_part(n_part[0]) : pack_part(n_part[1]);
        line.comp_len = n_semi_first ? clip_len(n_len[0]) : clip_len(n_len[1]);
        line.dest = pack_part(n_part[0]);
        line.dest_len = clip_len(n_len[0]);
        line.jump = n_semi_first ? pack_part(n_part[1]) : pack_part(n_part[2]);
        line.jump_len = n_semi_first ? clip_len(n_len[1]) : clip_len(n_len[2]);
    end

    assign o_line = line;
    assign o_line_valid = fire && finish && line.ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_count <= '0;
            r_in_comment <= 1'b0; r_slash <= 1'b0; r_started <= 1'b0;
            r_is_addr <= 1'b0; r_addr_bad <= 1'b0; r_digit <= 1'b0; r_addr <= '0;
            r_eq <= 1'b0; r_semi <= 1'b0; r_semi_first <= 1'b0;
            for (int s = 0; s < 3; s++) begin
                r_len[s] <= '0;
                for (int j = 0; j < TOKEN_CHARS; j++) r_part[s][j] <= '0;
            end
        end else if (fire) begin
            r_line_count <= n_line_count;
            if (clear) begin
                r_in_comment <= 1'b0; r_slash <= 1'b0; r_started <= 1'b0;
                r_is_addr <= 1'b0; r_addr_bad <= 1'b0; r_digit <= 1'b0; r_addr <= '0;
                r_eq <= 1'b0; r_semi <= 1'b0; r_semi_first <= 1'b0;
                for (int s = 0; s < 3; s++) begin
                    r_len[s] <= '0;
                    for (int j = 0; j < TOKEN_CHARS; j++) r_part[s][j] <= '0;
                end
            end else begin
                r_in_comment <= n_in_comment; r_slash <= n_slash; r_started <= n_started;
                r_is_addr <= n_is_addr; r_addr_bad <= n_addr_bad; r_digit <= n_digit;
                r_addr <= n_addr; r_eq <= n_eq; r_semi <= n_semi;
                r_semi_first <= n_semi_first; r_part <= n_part; r_len <= n_len;
            end
        end
    end
endmodule

// File: rtl/core/hale_queue.sv
module hale_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  hale_pkg::t_line i_data,
    output logic            o_ready,
    output logic            o_valid,
    output hale_pkg::t_line o_data,
    input  logic            i_ready
);
    import hale_pkg::*;

    t_line r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data = r_mem[r_rp];
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop) r_rp <= !r_rp;
            r_cnt <= 2'(r_cnt + {1'b0, push} - {1'b0, pop});
        end
    end
endmodule

// File: rtl/core/hale_back.sv
module hale_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  hale_pkg::t_line   i_line,
    output logic              o_ready,
    output logic              o_valid,
    output hale_pkg::t_result o_result,
    input  logic              i_ready,
    output logic              o_halted
);
    import hale_pkg::*;

    logic r_valid, r_halted;
    t_result r_res, res;
    logic take;

    function automatic logic [6:0] comp_code(input logic [31:0] t, input logic [3:0] l);
        logic [7:0] c0, c1, c2;
        logic [6:0] r;
        c0 = t[7:0]; c1 = t[15:8]; c2 = t[23:16];
        r = 7'h40;
        if (l == 4'd1) begin
            case (c0)
                "0": r = 7'h2A; "1": r = 7'h3F; "D": r = 7'h0C; "A": r = 7'h30;
                default: r = 7'h40;
            endcase
        end else if (l == 4'd2) begin
            case ({c0, c1})
                "-1": r = 7'h3A; "!D": r = 7'h0D; "!A": r = 7'h31;
                "-D": r = 7'h0F; "-A": r = 7'h33;
                default: r = 7'h40;
            endcase
        end else if (l == 4'd3) begin
            case ({c0, c1, c2})
                "D+1", "1+D": r = 7'h1F; "A+1", "1+A": r = 7'h37;
                "D-1": r = 7'h0E; "A-1": r = 7'h32; "D+A", "A+D": r = 7'h02;
                "D-A": r = 7'h13; "A-D": r = 7'h07; "D&A", "A&D": r = 7'h00;
                "D|A", "A|D": r = 7'h15;
                default: r = 7'h40;
            endcase
        end
        return r;
    endfunction

    function automatic logic [3:0] dest_code(input logic [31:0] t, input logic [3:0] l);
        logic [3:0] r;
        r = 4'h8;
        if (l == 4'd4 && t == {"l", "l", "u", "n"}) r = 4'd0;
        else if (l == 4'd1) begin
            case (t[7:0])
                "M": r = 4'd1; "D": r = 4'd2; "A": r = 4'd4;
                default: r = 4'h8;
            endcase
        end else if (l == 4'd2) begin
            case (t[15:0])
                {"D", "M"}: r = 4'd3; {"M", "A"}: r = 4'd5; {"D", "A"}: r = 4'd6;
                default: r = 4'h8;
            endcase
        end else if (l == 4'd3 && t[23:0] == {"D", "M", "A"}) r = 4'd7;
        return r;
    endfunction

    function automatic logic [3:0] jump_code(input logic [31:0] t, input logic [3:0] l);
        logic [3:0] r;
        r = 4'h8;
        if (l == 4'd4 && t == {"l", "l", "u", "n"}) r = 4'd0;
        else if (l == 4'd3) begin
            case (t[23:0])
                {"T", "G", "J"}: r = 4'd1; {"Q", "E", "J"}: r = 4'd2;
                {"E", "G", "J"}: r = 4'd3; {"T", "L", "J"}: r = 4'd4;
                {"E", "N", "J"}: r = 4'd5; {"E", "L", "J"}: r = 4'd6;
                {"P", "M", "J"}: r = 4'd7;
                default: r = 4'h8;
            endcase
        end
        return r;
    endfunction

    always_comb begin
        logic [31:0] cm;
        logic abit, done;
        logic [6:0] cc;
        logic [3:0] dc, jc;
        cm = i_line.comp;
        abit = 1'b0; done = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (!done && 4'(i) < i_line.comp_len && i_line.comp_len != 4'd15
                && cm[i*8 +: 8] == CH_M) begin
                cm[i*8 +: 8] = CH_A; abit = 1'b1; done = 1'b1;
            end
        end
        cc = comp_code(cm, i_line.comp_len);
        dc = i_line.semicolon_first ? 4'd0 : dest_code(i_line.dest, i_line.dest_len);
        jc = i_line.seen_semicolon ? jump_code(i_line.jump, i_line.jump_len) : 4'd0;
        res.line_number = i_line.line_number;
        res.instruction = '0;
        res.error_code = ERR_NONE;
        if (i_line.is_address) begin
            if (i_line.addr_bad) res.error_code = ERR_ADDRESS;
            else res.instruction = i_line.addr;
        end else if (i_line.format_bad) res.error_code = ERR_FORMAT;
        else if (cc[6]) res.error_code = ERR_COMP;
        else if (dc[3]) res.error_code = ERR_DEST;
        else if (jc[3]) res.error_code = ERR_JUMP;
        else res.instruction = {3'b111, abit, cc[5:0], dc[2:0], jc[2:0]};
    end

    assign o_ready = r_halted || !r_valid || i_ready;
    assign take = i_valid && o_ready && !r_halted;
    assign o_valid = r_valid;
    assign o_result = r_res;
    assign o_halted = r_halted;

    always_ff @(posedge i_clk) begin
        if (take) r_res <= res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0; r_halted <= 1'b0;
        end else begin
            if (take) begin
                r_valid <= 1'b1;
                if (res.error_code != ERR_NONE) r_halted <= 1'b1;
            end else if (i_ready) r_valid <= 1'b0;
        end
    end
endmodule

// File: rtl/core/hack_assembly_line_encoder.sv
// A line result passes through the two-entry line queue and then the result register after the line ends.
// Throughput: one character per cycle, but a line-ending character waits while the line queue is full.
// Reset: synchronous active-low i_rst_n clears line state, line count and the halt flag.
// After an error result the block drops every input until reset.
module hack_assembly_line_encoder #(
    parameter int TOKEN_CHARS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hale_stream_if.sink   s_in,
    hale_stream_if.source m_out
);
    import hale_pkg::*;
`include "hack_assembly_line_encoder_assert.svh"

    logic f_valid, q_ready, q_valid, b_ready, halted, h_hold;
    t_line f_line, q_line;
    t_result res;

    hale_front #(.TOKEN_CHARS(TOKEN_CHARS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_in.valid), .i_ch(s_in.data[7:0]), .i_end_of_text(s_in.data[8]),
        .o_ready(s_in.ready), .o_line_valid(f_valid), .o_line(f_line),
        .i_line_ready(q_ready), .i_halted(h_hold)
    );

    hale_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .i_data(f_line), .o_ready(q_ready),
        .o_valid(q_valid), .o_data(q_line), .i_ready(b_ready)
    );

    hale_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .i_line(q_line), .o_ready(b_ready),
        .o_valid(m_out.valid), .o_result(res), .i_ready(m_out.ready),
        .o_halted(halted)
    );

    assign h_hold = halted;
    assign m_out.data = res;

    `HALE_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, m_out.valid && res.error_code != ERR_NONE,
        res.instruction == 16'd0, "instruction not zero on error")
    `HALE_ASSERT_NEXT(a_halt_sticky, i_clk, i_rst_n, halted, halted, "halt flag dropped")
    `HALE_ASSERT_IMPL(a_line_nonzero, i_clk, i_rst_n, m_out.valid,
        res.line_number != 16'd0, "line number zero")
endmodule
